[design/mrtc_pkg.sv]
// Shared constants and register codes for the mesh route and transfer cost core.
package mrtc_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_COLS_DEF  = 8;

  localparam int CORE_W     = 6;
  localparam int RATE_W     = 24;
  localparam int ELEM_W     = 8;
  localparam int RATIO_W    = 16;
  localparam int HOP_ROW_W  = 6;
  localparam int HOP_COL_W  = 3;
  localparam int LINK_W     = 6;
  localparam int COUNT_W    = 32;
  localparam int FILL_W     = 10;
  localparam int PROD_W     = COUNT_W + RATIO_W;

  localparam int MCOLS_W    = 4;
  localparam int FLITW_W    = 7;
  localparam int STAGES_W   = 4;
  localparam int BW_W       = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_MESH_COLS      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLIT_WIDTH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROUTER_STAGES  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINK_BANDWIDTH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROUTE_ORDER    = 3'd4;

  localparam logic [MCOLS_W-1:0]  MESH_COLS_RST      = 4'd8;
  localparam logic [FLITW_W-1:0]  FLIT_WIDTH_RST     = 7'd16;
  localparam logic [STAGES_W-1:0] ROUTER_STAGES_RST  = 4'd3;
  localparam logic [BW_W-1:0]     LINK_BANDWIDTH_RST = 8'd1;

  localparam logic ORDER_XY = 1'b0;
  localparam logic ORDER_YX = 1'b1;

endpackage

[design/mrtc_if.sv]
// Valid/ready channel interfaces for transfer requests and route hop results.
interface mrtc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [mrtc_pkg::CORE_W-1:0]            producer_core;
  logic [mrtc_pkg::CORE_W-1:0]            consumer_core;
  logic                                   rate_present;
  logic [mrtc_pkg::RATE_W-1:0]            production_rate;
  logic [mrtc_pkg::ELEM_W-1:0]            element_size;
  logic [mrtc_pkg::RATIO_W-1:0]           ratio_num;
  logic [mrtc_pkg::RATIO_W-1:0]           ratio_den;

  modport source (
    output valid, producer_core, consumer_core, rate_present, production_rate,
           element_size, ratio_num, ratio_den,
    input  ready
  );
  modport sink (
    input  valid, producer_core, consumer_core, rate_present, production_rate,
           element_size, ratio_num, ratio_den,
    output ready
  );
endinterface

interface mrtc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [mrtc_pkg::HOP_ROW_W-1:0]         hop_row;
  logic [mrtc_pkg::HOP_COL_W-1:0]         hop_col;
  logic                                   last_hop;
  logic [mrtc_pkg::LINK_W-1:0]            link_count;
  logic [mrtc_pkg::COUNT_W-1:0]           flit_count;
  logic [mrtc_pkg::FILL_W-1:0]            fill_latency;
  logic [mrtc_pkg::COUNT_W-1:0]           serial_cycles;
  logic [mrtc_pkg::COUNT_W-1:0]           flits_per_cycle;

  modport source (
    output valid, hop_row, hop_col, last_hop, link_count, flit_count, fill_latency,
           serial_cycles, flits_per_cycle,
    input  ready
  );
  modport sink (
    input  valid, hop_row, hop_col, last_hop, link_count, flit_count, fill_latency,
           serial_cycles, flits_per_cycle,
    output ready
  );
endinterface

[design/mrtc_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module mrtc_serial_div #(
  parameter int DW = 32,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [DW-1:0] quo_next;
  logic [VW-1:0] acc;
  logic [VW-1:0] acc_next;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;
  logic          take;

  always_comb begin
    shifted  = {acc, quo[DW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    take     = ~diff[VW+1];
    acc_next = take ? diff[VW-1:0] : shifted[VW-1:0];
    quo_next = {quo[DW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= CW'(DW);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      acc <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= quo_next;
      acc <= acc_next;
    end
  end

  assign busy      = run;
  assign quotient  = quo;
  assign remainder = acc;

endmodule

[design/mrtc_route_walk.sv]
// Dimension-order route walker that steps one mesh node per accepted hop.
module mrtc_route_walk #(
  parameter int MAX_NODES = 64,
  parameter int ROW_W     = 6,
  parameter int COL_W     = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ROW_W-1:0] src_row,
  input  logic [COL_W-1:0] src_col,
  input  logic [ROW_W-1:0] dst_row,
  input  logic [COL_W-1:0] dst_col,
  input  logic             order,
  input  logic             adv,
  output logic             active,
  output logic [ROW_W-1:0] row,
  output logic [COL_W-1:0] col,
  output logic             last
);

  localparam int NW = $clog2(MAX_NODES);

  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] dr;
  logic [COL_W-1:0] dc;
  logic             ord;
  logic [NW-1:0]    n;
  logic             act;
  logic             move_col;
  logic             step;

  always_comb begin
    last     = ((r == dr) && (c == dc)) || (n == NW'(MAX_NODES - 1));
    move_col = (ord == mrtc_pkg::ORDER_XY) ? (c != dc) : (r == dr);
    step     = act && adv && !last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (start) begin
      act <= 1'b1;
    end else if (act && adv && last) begin
      act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= src_row;
      c   <= src_col;
      dr  <= dst_row;
      dc  <= dst_col;
      ord <= order;
      n   <= '0;
    end else if (step) begin
      n <= n + 1'b1;
      if (move_col) begin
        c <= (dc > c) ? c + 1'b1 : c - 1'b1;
      end else begin
        r <= (dr > r) ? r + 1'b1 : r - 1'b1;
      end
    end
  end

  assign active = act;
  assign row    = r;
  assign col    = c;

endmodule

[design/mesh_route_and_transfer_cost_core.sv]
// Top level: mesh route walk with serial ceiling divisions for transfer cost.
// The first hop result follows an input transaction through a load state, serial divisions for
// the core row/column and the flit count, the S_MUL and S_LOAD2 product states, and serial
// divisions for serialization and flits per cycle; then one hop per cycle while hop.ready is high.
// A new transaction is taken the cycle after the last hop is delivered; equal cores finish at once.
// Synchronous active-high reset restores the configuration registers to their defaults.
module mesh_route_and_transfer_cost_core #(
  parameter int MAX_NODES = mrtc_pkg::MAX_NODES_DEF,
  parameter int MAX_COLS  = mrtc_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mrtc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mrtc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  mrtc_in_if.sink                           xfer,
  mrtc_out_if.source                        hop
);

  localparam int CVW   = $clog2(MAX_COLS + 1);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = mrtc_pkg::HOP_ROW_W;
  localparam int CW    = mrtc_pkg::COUNT_W;
  localparam int PW    = mrtc_pkg::PROD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_LOAD2 = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [mrtc_pkg::MCOLS_W-1:0]  mesh_cols;
  logic [mrtc_pkg::FLITW_W-1:0]  flit_width;
  logic [mrtc_pkg::STAGES_W-1:0] router_stages;
  logic [mrtc_pkg::BW_W-1:0]     link_bandwidth;
  logic                          route_order;

  logic [mrtc_pkg::CORE_W-1:0]   prod;
  logic [mrtc_pkg::CORE_W-1:0]   cons;
  logic [mrtc_pkg::RATIO_W-1:0]  num;
  logic [mrtc_pkg::RATIO_W-1:0]  den;
  logic [CW-1:0]                 bytes;
  logic [CW-1:0]                 flits;
  logic [ROW_W-1:0]              sr;
  logic [ROW_W-1:0]              dr;
  logic [COL_W-1:0]              sc;
  logic [COL_W-1:0]              dc;
  logic [mrtc_pkg::LINK_W-1:0]   links;
  logic [PW-1:0]                 fdprod;
  logic [mrtc_pkg::FILL_W-1:0]   fill;
  logic [CW-1:0]                 serial;
  logic [CW-1:0]                 fpc;

  logic [CVW-1:0]                cols_eff;
  logic [mrtc_pkg::FLITW_W-1:0]  fw_eff;
  logic [mrtc_pkg::RATE_W-1:0]   rate_eff;
  logic [ROW_W-1:0]              rdiff;
  logic [COL_W-1:0]              cdiff;
  logic [PW-1:0]                 fpc_ceil;
  logic                          accept;
  logic                          adv;
  logic                          start1;
  logic                          start2;
  logic                          walk_start;

  logic                          sbusy;
  logic                          dbusy;
  logic                          fbusy;
  logic                          vbusy;
  logic                          pbusy;
  logic [ROW_W-1:0]              squo;
  logic [ROW_W-1:0]              dquo;
  logic [CVW-1:0]                srem;
  logic [CVW-1:0]                drem;
  logic [CW-1:0]                 fquo;
  logic [mrtc_pkg::FLITW_W-1:0]  frem;
  logic [CW-1:0]                 vquo;
  logic [mrtc_pkg::BW_W-1:0]     vrem;
  logic [PW-1:0]                 pquo;
  logic [mrtc_pkg::RATIO_W-1:0]  prem;

  logic                          walk_active;
  logic [ROW_W-1:0]              walk_row;
  logic [COL_W-1:0]              walk_col;
  logic                          walk_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_cols      <= mrtc_pkg::MESH_COLS_RST;
      flit_width     <= mrtc_pkg::FLIT_WIDTH_RST;
      router_stages  <= mrtc_pkg::ROUTER_STAGES_RST;
      link_bandwidth <= mrtc_pkg::LINK_BANDWIDTH_RST;
      route_order    <= mrtc_pkg::ORDER_XY;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrtc_pkg::CFG_MESH_COLS:      mesh_cols      <= cfg_wdata[mrtc_pkg::MCOLS_W-1:0];
        mrtc_pkg::CFG_FLIT_WIDTH:     flit_width     <= cfg_wdata[mrtc_pkg::FLITW_W-1:0];
        mrtc_pkg::CFG_ROUTER_STAGES:  router_stages  <= cfg_wdata[mrtc_pkg::STAGES_W-1:0];
        mrtc_pkg::CFG_LINK_BANDWIDTH: link_bandwidth <= cfg_wdata[mrtc_pkg::BW_W-1:0];
        mrtc_pkg::CFG_ROUTE_ORDER:    route_order    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mesh_cols == '0) begin
      cols_eff = CVW'(1);
    end else if (int'(mesh_cols) > MAX_COLS) begin
      cols_eff = CVW'(MAX_COLS);
    end else begin
      cols_eff = CVW'(mesh_cols);
    end
    fw_eff     = (flit_width == '0) ? mrtc_pkg::FLITW_W'(1) : flit_width;
    rate_eff   = xfer.rate_present ? xfer.production_rate : mrtc_pkg::RATE_W'(1);
    rdiff      = (sr >= dr) ? sr - dr : dr - sr;
    cdiff      = (sc >= dc) ? sc - dc : dc - sc;
    fpc_ceil   = pquo + PW'(|prem);
    accept     = xfer.valid && xfer.ready;
    adv        = hop.valid && hop.ready;
    start1     = (state == S_LOAD);
    start2     = (state == S_LOAD2);
    walk_start = (state == S_DIV2) && !vbusy && !pbusy;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (xfer.producer_core != xfer.consumer_core)) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD:  state_next = S_DIV1;
      S_DIV1: begin
        if (!sbusy && !dbusy && !fbusy) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_LOAD2;
      S_LOAD2: state_next = S_DIV2;
      S_DIV2: begin
        if (walk_start) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (adv && walk_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod  <= xfer.producer_core;
      cons  <= xfer.consumer_core;
      num   <= xfer.ratio_num;
      den   <= xfer.ratio_den;
      bytes <= {{(CW - mrtc_pkg::RATE_W){1'b0}}, rate_eff}
             * {{(CW - mrtc_pkg::ELEM_W){1'b0}}, xfer.element_size};
    end
    if ((state == S_DIV1) && (state_next == S_MUL)) begin
      flits <= fquo + CW'(|frem);
      sr    <= squo;
      dr    <= dquo;
      sc    <= COL_W'(srem);
      dc    <= COL_W'(drem);
    end
    if (state == S_MUL) begin
      fdprod <= {{(PW - CW){1'b0}}, flits} * {{(PW - mrtc_pkg::RATIO_W){1'b0}}, den};
      links  <= mrtc_pkg::LINK_W'(rdiff) + mrtc_pkg::LINK_W'(cdiff);
    end
    if (state == S_LOAD2) begin
      fill <= {{(mrtc_pkg::FILL_W - mrtc_pkg::LINK_W){1'b0}}, links}
            * {{(mrtc_pkg::FILL_W - mrtc_pkg::STAGES_W){1'b0}}, router_stages};
    end
    if (walk_start) begin
      serial <= (link_bandwidth == '0) ? flits : vquo + CW'(|vrem);
      if ((num == '0) || (den == '0)) begin
        fpc <= flits;
      end else if (fpc_ceil[PW-1:CW] != '0) begin
        fpc <= '1;
      end else begin
        fpc <= fpc_ceil[CW-1:0];
      end
    end
  end

  mrtc_serial_div #(.DW(mrtc_pkg::CORE_W), .VW(CVW)) u_src_div (
    .clk(clk), .rst(rst), .start(start1), .dividend(prod), .divisor(cols_eff),
    .busy(sbusy), .quotient(squo), .remainder(srem)
  );

  mrtc_serial_div #(.DW(mrtc_pkg::CORE_W), .VW(CVW)) u_dst_div (
    .clk(clk), .rst(rst), .start(start1), .dividend(cons), .divisor(cols_eff),
    .busy(dbusy), .quotient(dquo), .remainder(drem)
  );

  mrtc_serial_div #(.DW(CW), .VW(mrtc_pkg::FLITW_W)) u_flit_div (
    .clk(clk), .rst(rst), .start(start1), .dividend(bytes), .divisor(fw_eff),
    .busy(fbusy), .quotient(fquo), .remainder(frem)
  );

  mrtc_serial_div #(.DW(CW), .VW(mrtc_pkg::BW_W)) u_serial_div (
    .clk(clk), .rst(rst), .start(start2), .dividend(flits), .divisor(link_bandwidth),
    .busy(vbusy), .quotient(vquo), .remainder(vrem)
  );

  mrtc_serial_div #(.DW(PW), .VW(mrtc_pkg::RATIO_W)) u_ratio_div (
    .clk(clk), .rst(rst), .start(start2), .dividend(fdprod), .divisor(num),
    .busy(pbusy), .quotient(pquo), .remainder(prem)
  );

  mrtc_route_walk #(.MAX_NODES(MAX_NODES), .ROW_W(ROW_W), .COL_W(COL_W)) u_walk (
    .clk(clk), .rst(rst), .start(walk_start),
    .src_row(sr), .src_col(sc), .dst_row(dr), .dst_col(dc),
    .order(route_order), .adv(adv),
    .active(walk_active), .row(walk_row), .col(walk_col), .last(walk_last)
  );

  assign xfer.ready          = (state == S_IDLE);
  assign hop.valid           = walk_active;
  assign hop.hop_row         = walk_row;
  assign hop.hop_col         = mrtc_pkg::HOP_COL_W'(walk_col);
  assign hop.last_hop        = walk_last;
  assign hop.link_count      = links;
  assign hop.flit_count      = flits;
  assign hop.fill_latency    = fill;
  assign hop.serial_cycles   = serial;
  assign hop.flits_per_cycle = fpc;

endmodule
